FILE: rtl/core/bq_pkg.sv
// shared types, constants and register map of the butterworth biquad
`default_nettype none

package bq_pkg;

  localparam int unsigned HIST_W     = 48;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned GAIN_W     = 31;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 30;
  localparam int HIST_FRAC_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_GAIN = 4'd0,
    CFG_FB_OLDER = 4'd1,
    CFG_FB_NEWER = 4'd2,
    CFG_MID_NEG  = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]        inv_gain;
    logic signed [COEF_W-1:0] fb_older;
    logic signed [COEF_W-1:0] fb_newer;
    logic                     mid_neg;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inv_gain: 31'd740136862,
    fb_older: -32'sd512810774,
    fb_newer: -32'sd1373994855,
    mid_neg:  1'b0
  };

  typedef logic signed [HIST_W-1:0] hist_t;

  localparam hist_t HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam hist_t HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/core/bq_if.sv
// channel interfaces: sample input, filtered output and register writes
`default_nettype none

interface bq_in_if #(
  parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           restart;

  modport source (output valid, sample_in, restart, input ready);
  modport sink   (input valid, sample_in, restart, output ready);
endinterface

interface bq_out_if #(
  parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface

interface bq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bq_pkg::CFG_IDX_W-1:0]    index;
  logic [bq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/butterworth_biquad_df1.sv
// second-order butterworth biquad, direct form 1, fixed point
// channels: in_i carries sample_in and restart, out_o carries sample_out and clipped,
//   both valid/ready; a transaction moves when valid and ready are high at a clock edge
// cfg_i writes register index/data: 0 inv_gain, 1 feedback_older, 2 feedback_newer,
//   3 middle_tap_negative; it is always ready, other indexes are ignored
// restart on an input transaction clears all history before that sample is filtered
// three register stages: input scaling, recursive tap sum, output saturation
// accepted samples pass the scale, tap-sum and saturation registers on to out_o
// throughput: one sample per cycle unless out_o stalls; the cycle is set by the
//   feedback path: a 32x32 and a 17x32 multiply per tap, five-term add, saturation
// reset loads the default coefficients (low-pass) and clears history and valids
// when out_o stalls, each stage holds and in_i.ready drops only once all three
//   stages hold data, so up to three transactions sit in flight
`default_nettype none

module butterworth_biquad_df1 #(
  parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF,
  parameter int HIST_FRAC_BITS = bq_pkg::HIST_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bq_in_if.sink     in_i,
  bq_out_if.source  out_o,
  bq_cfg_if.sink    cfg_i
);
  import bq_pkg::*;

  cfg_t  cfg;
  logic  sc_valid;
  hist_t sc_x;
  logic  sc_restart;
  logic  fb_ready;
  logic  fb_valid;
  hist_t fb_y;
  logic  sat_ready;

  bq_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bq_scale #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .HIST_FRAC_BITS (HIST_FRAC_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .inv_gain_i (cfg.inv_gain),
    .ready_i    (fb_ready),
    .valid_o    (sc_valid),
    .x_o        (sc_x),
    .restart_o  (sc_restart)
  );

  bq_fb #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_fb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (sc_valid),
    .x_i       (sc_x),
    .restart_i (sc_restart),
    .ready_o   (fb_ready),
    .ready_i   (sat_ready),
    .valid_o   (fb_valid),
    .y_o       (fb_y)
  );

  bq_sat #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .HIST_FRAC_BITS (HIST_FRAC_BITS)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fb_valid),
    .y_i     (fb_y),
    .ready_o (sat_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bq_cfg.sv
// configuration register file of the biquad
`default_nettype none

module bq_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  bq_cfg_if.sink        cfg_i,
  output bq_pkg::cfg_t  cfg_o
);
  import bq_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_INV_GAIN: cfg_d.inv_gain = cfg_i.data[GAIN_W-1:0];
        CFG_FB_OLDER: cfg_d.fb_older = $signed(cfg_i.data[COEF_W-1:0]);
        CFG_FB_NEWER: cfg_d.fb_newer = $signed(cfg_i.data[COEF_W-1:0]);
        CFG_MID_NEG:  cfg_d.mid_neg  = cfg_i.data[0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bq_scale.sv
// input stage: scales each sample by the inverse gain into history format
`default_nettype none

module bq_scale #(
  parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF,
  parameter int HIST_FRAC_BITS = bq_pkg::HIST_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bq_in_if.sink                       in_i,
  input  logic [bq_pkg::GAIN_W-1:0]   inv_gain_i,
  input  logic                        ready_i,
  output logic                        valid_o,
  output bq_pkg::hist_t               x_o,
  output logic                        restart_o
);
  import bq_pkg::*;

  localparam int SH   = COEF_FRAC_BITS - HIST_FRAC_BITS;
  localparam int SH_R = (SH > 0) ? SH : 0;
  localparam int SH_L = (SH < 0) ? -SH : 0;
  localparam int PW   = SAMPLE_WIDTH + GAIN_W + 1;
  // never narrower than the history, so the saturation compare and select stay in range
  localparam int XW   = (PW + SH_L > HIST_W) ? PW + SH_L : HIST_W;

  logic signed [PW-1:0] samp_ext;
  logic signed [PW-1:0] gain_ext;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] x_wide;
  hist_t                x_sat;
  logic                 accept;

  logic  valid_q;
  hist_t x_q;
  logic  restart_q;

  assign in_i.ready = !valid_q || ready_i;
  assign accept     = in_i.valid && in_i.ready;

  assign samp_ext = PW'(in_i.sample_in);
  assign gain_ext = PW'({1'b0, inv_gain_i});
  assign prod     = samp_ext * gain_ext;

  // one of the two shifts is always zero
  assign x_wide = (XW'(prod) <<< SH_L) >>> SH_R;

  always_comb begin
    if (x_wide > XW'(HIST_MAX)) begin
      x_sat = HIST_MAX;
    end else if (x_wide < XW'(HIST_MIN)) begin
      x_sat = HIST_MIN;
    end else begin
      x_sat = x_wide[HIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q       <= x_sat;
      restart_q <= in_i.restart;
    end
  end

  assign valid_o   = valid_q;
  assign x_o       = x_q;
  assign restart_o = restart_q;

endmodule

`default_nettype wire

FILE: rtl/core/bq_fb.sv
// recursive stage: tap sum, feedback products and history registers
`default_nettype none

module bq_fb #(
  parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bq_pkg::cfg_t   cfg_i,
  input  logic           valid_i,
  input  bq_pkg::hist_t  x_i,
  input  logic           restart_i,
  output logic           ready_o,
  input  logic           ready_i,
  output logic           valid_o,
  output bq_pkg::hist_t  y_o
);
  import bq_pkg::*;

  localparam int LO_W   = 16;
  localparam int HI_W   = HIST_W - LO_W;
  localparam int FULL_W = HIST_W + COEF_W;
  localparam int PC_W   = 58;  // holds +-2^56
  localparam int SUM_W  = PC_W + 3;
  localparam int MID_W  = HIST_W + 2;

  localparam logic signed [PC_W-1:0] PC_MAX = {2'b01, {(PC_W-2){1'b0}}};
  localparam logic signed [PC_W-1:0] PC_MIN = {2'b11, {(PC_W-2){1'b0}}};

  // floor(y * c / 2^frac) clamped to +-2^56, split into a high and a low partial product
  function automatic logic signed [PC_W-1:0] fb_prod(hist_t y,
                                                      logic signed [COEF_W-1:0] c);
    logic signed [HI_W-1:0]          hi;
    logic signed [LO_W:0]            lo;
    logic signed [HI_W+COEF_W-1:0]   ph;
    logic signed [LO_W+COEF_W:0]     pl;
    logic signed [FULL_W-1:0]        full;
    logic signed [FULL_W-1:0]        shr;
    logic signed [PC_W-1:0]          res;
    hi   = y[HIST_W-1:LO_W];
    lo   = $signed({1'b0, y[LO_W-1:0]});
    ph   = hi * c;
    pl   = lo * c;
    full = (FULL_W'(ph) <<< LO_W) + FULL_W'(pl);
    shr  = full >>> COEF_FRAC_BITS;
    if (shr > FULL_W'(PC_MAX)) begin
      res = PC_MAX;
    end else if (shr < FULL_W'(PC_MIN)) begin
      res = PC_MIN;
    end else begin
      res = shr[PC_W-1:0];
    end
    return res;
  endfunction

  hist_t xh1_q, xh2_q, yh1_q, yh2_q;
  hist_t xh1, xh2, yh1, yh2;
  logic signed [MID_W-1:0] h1_ext;
  logic signed [MID_W-1:0] mid;
  logic signed [PC_W-1:0]  p_old;
  logic signed [PC_W-1:0]  p_new;
  logic signed [SUM_W-1:0] sum;
  hist_t                   y_sat;
  logic                    accept;

  logic  valid_q;
  hist_t y_q;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // restart clears history ahead of this sample
  assign xh1 = restart_i ? '0 : xh1_q;
  assign xh2 = restart_i ? '0 : xh2_q;
  assign yh1 = restart_i ? '0 : yh1_q;
  assign yh2 = restart_i ? '0 : yh2_q;

  assign h1_ext = MID_W'(xh1);
  assign mid    = cfg_i.mid_neg ? -(h1_ext <<< 1) : (h1_ext <<< 1);
  assign p_old  = fb_prod(yh2, cfg_i.fb_older);
  assign p_new  = fb_prod(yh1, cfg_i.fb_newer);

  assign sum = SUM_W'(x_i) + SUM_W'(mid) + SUM_W'(xh2) + SUM_W'(p_old) + SUM_W'(p_new);

  always_comb begin
    if (sum > SUM_W'(HIST_MAX)) begin
      y_sat = HIST_MAX;
    end else if (sum < SUM_W'(HIST_MIN)) begin
      y_sat = HIST_MIN;
    end else begin
      y_sat = sum[HIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh1_q <= '0;
      xh2_q <= '0;
      yh1_q <= '0;
      yh2_q <= '0;
    end else if (accept) begin
      xh2_q <= xh1;
      xh1_q <= x_i;
      yh2_q <= yh1;
      yh1_q <= y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      y_q <= y_sat;
    end
  end

  assign valid_o = valid_q;
  assign y_o     = y_q;

endmodule

`default_nettype wire

FILE: rtl/core/bq_sat.sv
// output stage: truncation toward zero, saturation and clip flag
`default_nettype none

module bq_sat #(
  parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
  parameter int HIST_FRAC_BITS = bq_pkg::HIST_FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  bq_pkg::hist_t  y_i,
  output logic           ready_o,
  bq_out_if.source       out_o
);
  import bq_pkg::*;

  localparam hist_t SMAX = hist_t'({(SAMPLE_WIDTH-1){1'b1}});
  localparam hist_t SMIN = ~SMAX;

  hist_t bias;
  hist_t y_biased;
  hist_t t_full;
  logic signed [SAMPLE_WIDTH-1:0] samp_d;
  logic  clip_d;
  logic  accept;

  logic  valid_q;
  logic signed [SAMPLE_WIDTH-1:0] samp_q;
  logic  clip_q;

  assign ready_o = !valid_q || out_o.ready;
  assign accept  = valid_i && ready_o;

  // negative values get a bias so the shift rounds toward zero
  assign bias     = y_i[HIST_W-1] ? hist_t'({HIST_FRAC_BITS{1'b1}}) : '0;
  assign y_biased = y_i + bias;
  assign t_full   = y_biased >>> HIST_FRAC_BITS;

  always_comb begin
    if (t_full > SMAX) begin
      samp_d = SMAX[SAMPLE_WIDTH-1:0];
      clip_d = 1'b1;
    end else if (t_full < SMIN) begin
      samp_d = SMIN[SAMPLE_WIDTH-1:0];
      clip_d = 1'b1;
    end else begin
      samp_d = t_full[SAMPLE_WIDTH-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= samp_d;
      clip_q <= clip_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.sample_out = samp_q;
  assign out_o.clipped    = clip_q;

endmodule

`default_nettype wire

FILE: dv/biquad_scoreboard_pkg.sv
// scoreboard for the butterworth biquad: predicts filtered samples and checks the output stream
`timescale 1ns / 1ps

package biquad_scoreboard_pkg;
  import bq_pkg::*;

  localparam int SAMPLE_W  = SAMPLE_WIDTH_DEF;
  localparam int COEF_FRAC = COEF_FRAC_BITS_DEF;
  localparam int HIST_FRAC = HIST_FRAC_BITS_DEF;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } filtered_t;

  class biquad_scoreboard;
    cfg_t        regs;
    hist_t       x_prev1, x_prev2, y_prev1, y_prev2;
    filtered_t   expected_samples[$];
    int unsigned errors;

    function new();
      regs    = CFG_RESET;
      x_prev1 = '0;
      x_prev2 = '0;
      y_prev1 = '0;
      y_prev2 = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_INV_GAIN: regs.inv_gain = data[GAIN_W-1:0];
        CFG_FB_OLDER: regs.fb_older = data;
        CFG_FB_NEWER: regs.fb_newer = data;
        CFG_MID_NEG:  regs.mid_neg  = data[0];
        default: ;
      endcase
    endfunction

    // floor(h * c / 2^frac), bounded well outside the history range
    function longint feedback_term(hist_t h, logic signed [COEF_W-1:0] c);
      logic signed [HIST_W+COEF_W-1:0] prod;
      longint                          bound;
      bound = longint'(1) <<< 56;
      prod  = h * c;
      prod  = prod >>> COEF_FRAC;
      if (prod > bound) prod = bound;
      else if (prod < -bound) prod = -bound;
      return longint'(prod);
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic restart);
      longint    x, mid, total, q, smax, smin;
      hist_t     y;
      filtered_t r;
      smax = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
      smin = -smax - 1;
      if (restart) begin
        x_prev1 = '0;
        x_prev2 = '0;
        y_prev1 = '0;
        y_prev2 = '0;
      end
      x   = (longint'(s) * longint'(regs.inv_gain)) >>> (COEF_FRAC - HIST_FRAC);
      mid = 2 * longint'(x_prev1);
      if (regs.mid_neg) mid = -mid;
      total = x + mid + longint'(x_prev2)
            + feedback_term(y_prev2, regs.fb_older)
            + feedback_term(y_prev1, regs.fb_newer);
      if (total > longint'(HIST_MAX)) y = HIST_MAX;
      else if (total < longint'(HIST_MIN)) y = HIST_MIN;
      else y = hist_t'(total);
      x_prev2 = x_prev1;
      x_prev1 = hist_t'(x);
      y_prev2 = y_prev1;
      y_prev1 = y;
      // truncate toward zero, then saturate
      if (y >= 0) q = longint'(y) >>> HIST_FRAC;
      else q = -((-longint'(y)) >>> HIST_FRAC);
      r.clipped = 1'b0;
      if (q > smax) begin
        q = smax;
        r.clipped = 1'b1;
      end else if (q < smin) begin
        q = smin;
        r.clipped = 1'b1;
      end
      r.sample = q[SAMPLE_W-1:0];
      expected_samples.push_back(r);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] s, logic clip);
      filtered_t e;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected output sample %0d clipped %0b", $time, s, clip);
        return;
      end
      e = expected_samples.pop_front();
      if (s !== e.sample || clip !== e.clipped) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: output sample %0d clipped %0b, expected sample %0d clipped %0b",
                   $time, s, clip, e.sample, e.clipped);
      end
    endfunction
  endclass

endpackage

FILE: dv/tb_butterworth_biquad_df1.sv
// testbench top: drives samples and register writes into the biquad and checks every output
`timescale 1ns / 1ps

module tb_butterworth_biquad_df1;
  import bq_pkg::*;
  import biquad_scoreboard_pkg::*;

  localparam int          NUM_BLOCKS       = 6;
  localparam int          BLOCK_ITEMS      = 125;
  localparam int          DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD        = 300;
  localparam int          FIRST_UNUSED_IDX = CFG_MID_NEG + 1;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req = 1'b0;

  biquad_scoreboard sb;
  cfg_t             block_cfg[NUM_BLOCKS];

  bq_in_if  in_if ();
  bq_out_if out_if ();
  bq_cfg_if cfg_if ();

  butterworth_biquad_df1 dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: random back-pressure plus a long hold-off on request
  initial begin
    int unsigned held;
    held = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        held = LONG_HOLD;
      end
      if (held != 0) begin
        held--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.sample_out, out_if.clipped);
  end

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic rs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    in_if.restart   <= rs;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s, rs);
  endtask

  // leaves valid high; the caller lowers it after the last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  // junk in the unused upper bits must be ignored
  task automatic program_regs(cfg_t c);
    cfg_write(CFG_INV_GAIN, {1'($urandom), c.inv_gain});
    cfg_write(CFG_FB_OLDER, c.fb_older);
    cfg_write(CFG_FB_NEWER, c.fb_newer);
    cfg_write(CFG_MID_NEG, {31'($urandom), c.mid_neg});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return $signed(16'($urandom_range(0, 511) - 256));
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    return '{inv_gain: 31'($urandom), fb_older: 32'($urandom),
             fb_newer: 32'($urandom), mid_neg: 1'($urandom)};
  endfunction

  initial begin
    #2_000_000;
    $display("butterworth_biquad_df1: mismatch");
    $finish;
  end

  initial begin
    cfg_t extreme;
    sb = new();
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    in_if.restart   = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    send_idle_pct   = 23;
    recv_idle_pct   = 72;

    block_cfg[0] = CFG_RESET;
    // high-pass set with its cutoff near dc
    block_cfg[1] = '{inv_gain: 31'd1071755930, fb_older: -32'sd1069773724,
                     fb_newer: 32'sd2143508228, mid_neg: 1'b1};
    block_cfg[2] = random_cfg();
    block_cfg[3] = '{inv_gain: '0, fb_older: '0, fb_newer: 32'sh8000_0000, mid_neg: 1'b0};
    block_cfg[4] = CFG_RESET;
    block_cfg[4].inv_gain = {GAIN_W{1'b1}};
    block_cfg[5] = random_cfg();
    extreme = '{inv_gain: {GAIN_W{1'b1}}, fb_older: 32'sh8000_0000,
                fb_newer: 32'sh7FFF_FFFF, mid_neg: 1'b1};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients, low-pass: full-scale steps, small values, restart mid-stream
    send_sample(16'sh7FFF, 1'b1);
    repeat (3) send_sample(16'sh7FFF, 1'b0);
    repeat (3) send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(-16'sh0001, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    drain();

    // unstable extreme set: output clips and history saturates; stray index is ignored
    cfg_write(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, 2**CFG_IDX_W - 1)), $urandom);
    program_regs(extreme);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    repeat (3) send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b1);

    for (int b = 0; b < NUM_BLOCKS; b++) begin
      drain();
      if (b == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 23;
      end else if (b == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_regs(block_cfg[b]);
      // sender keeps offering while the output is held, so the pipeline fills
      if (b == 4) hold_off_req = 1'b1;
      for (int i = 0; i < BLOCK_ITEMS; i++)
        send_sample(pick_sample(), $urandom_range(0, 99) < 3);
    end
    drain();

    if (sb.errors == 0) begin
      $display("butterworth_biquad_df1: match");
    end else begin
      $display("butterworth_biquad_df1: mismatch");
    end
    $finish;
  end

endmodule

FILE: butterworth_biquad_df1.f
rtl/core/bq_pkg.sv
rtl/core/bq_if.sv
rtl/core/bq_cfg.sv
rtl/core/bq_scale.sv
rtl/core/bq_fb.sv
rtl/core/bq_sat.sv
rtl/core/butterworth_biquad_df1.sv
dv/biquad_scoreboard_pkg.sv
dv/tb_butterworth_biquad_df1.sv
